// ===== sv/hrwo_pkg.sv =====
// ----------------------------------------------------------------------------
// Hashed random word offset package
// Constants shared by the offset unit and its checker.
// ----------------------------------------------------------------------------
`default_nettype none
package hrwo_pkg;
  localparam int WORD_BYTES = 8;
  localparam int PASS_W = 64;
  localparam int INDEX_W = 64;
  localparam int SEED_W = 64;
  localparam int ARENA_W = 41;
  localparam int OFFSET_W = 43;
  localparam int CFG_W = 64;
  localparam int WB_W = $clog2(WORD_BYTES + 1);

  localparam logic [0:0] REG_SEED = 1'b0;
  localparam logic [0:0] REG_ARENA = 1'b1;

  localparam logic [63:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MUL_ONE = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MUL_TWO = 64'h94d049bb133111eb;
  localparam logic [63:0] INDEX_MUL = 64'hd6e8feb86659fd93;
  localparam logic [40:0] ARENA_MAX = 41'h100_0000_0000;

  localparam int MOD_STEPS = 64;
endpackage
`default_nettype wire

// ===== sv/hrwo_mul64.sv =====
// ----------------------------------------------------------------------------
// Pipelined 64 by 64 low-half multiplier
// Three 32 by 32 partial products in stage one, summed in stage two.
// ----------------------------------------------------------------------------
`default_nettype none
module hrwo_mul64 (
  input  wire logic        clk,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic      [63:0] p
);
  import hrwo_pkg::*;

  logic [63:0] ll;
  logic [31:0] lh;
  logic [31:0] hl;

  always_ff @(posedge clk) begin
    ll <= 64'(a[31:0]) * 64'(b[31:0]);
    lh <= 32'(a[31:0] * b[63:32]);
    hl <= 32'(a[63:32] * b[31:0]);
    p <= ll + {lh + hl, 32'd0};
  end
endmodule
`default_nettype wire

// ===== sv/hashed_random_word_offset_unit.sv =====
// ----------------------------------------------------------------------------
// Hashed random word offset unit
// Two splitmix64 finalizers, a restoring modulo pipeline and word scaling.
// ----------------------------------------------------------------------------
// channel   signals                                 direction
// command   start, busy, pass_number, access_index  in
// result    done, byte_offset                       out
// config    cfg_we, cfg_index, cfg_data             in
// One transaction enters every cycle; busy stays low.
// A result passes 10 + 64 + 1 = 75 register stages between start and done.
// The finalizer multipliers and the 64-step remainder pipeline set the depth.
// Reset clears the config registers and all valid bits; the receiver cannot stall.
`default_nettype none
module hashed_random_word_offset_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [hrwo_pkg::PASS_W-1:0]      pass_number,
  input  wire logic [hrwo_pkg::INDEX_W-1:0]     access_index,
  output logic                                  done,
  output logic      [hrwo_pkg::OFFSET_W-1:0]    byte_offset,
  input  wire logic                             cfg_we,
  input  wire logic                             cfg_index,
  input  wire logic [hrwo_pkg::CFG_W-1:0]       cfg_data
);
  import hrwo_pkg::*;

  localparam int FL = 4;
  localparam int LAT = 2 * FL + 2;

  logic [SEED_W-1:0] seed;
  logic [ARENA_W-1:0] arena;
  logic [ARENA_W-1:0] words;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
      arena <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEED: seed <= cfg_data;
        REG_ARENA: arena <= cfg_data[ARENA_W-1:0];
        default: ;
      endcase
    end
  end

  assign words = (arena > ARENA_MAX) ? ARENA_MAX : arena;
  assign busy = 1'b0;

  logic [63:0] a0, a1, a2, b1, b2, b3, c1, c2;
  logic [63:0] ip, ipd [FL-1];
  logic [63:0] m1, m2, m3, m4;
  logic [LAT-1:0] vld;

  hrwo_mul64 u_mi (.clk(clk), .a(access_index), .b(INDEX_MUL), .p(ip));

  always_ff @(posedge clk) begin
    a0 <= pass_number + GOLDEN_INC;
    ipd[0] <= ip;
    for (int i = 1; i < FL - 1; i++) ipd[i] <= ipd[i-1];
  end
  hrwo_mul64 u_m1 (.clk(clk), .a(a0 ^ (a0 >> 30)), .b(MUL_ONE), .p(m1));
  hrwo_mul64 u_m2 (.clk(clk), .a(m1 ^ (m1 >> 27)), .b(MUL_TWO), .p(m2));
  always_ff @(posedge clk) begin
    b1 <= (seed ^ m2 ^ (m2 >> 31) ^ ipd[FL-2]) + GOLDEN_INC;
  end
  hrwo_mul64 u_m3 (.clk(clk), .a(b1 ^ (b1 >> 30)), .b(MUL_ONE), .p(m3));
  hrwo_mul64 u_m4 (.clk(clk), .a(m3 ^ (m3 >> 27)), .b(MUL_TWO), .p(m4));
  assign c1 = m4 ^ (m4 >> 31);
  assign a1 = '0;
  assign a2 = a1;
  assign b2 = b1;
  assign b3 = b2;
  assign c2 = c1;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[LAT-2:0], start};
  end

  logic [63:0] qv [MOD_STEPS+1];
  logic [ARENA_W:0] rv [MOD_STEPS+1];
  logic [MOD_STEPS:0] mv;
  logic [ARENA_W:0] rs [MOD_STEPS];

  assign qv[0] = c2 ^ a2 ^ (b3 & 64'd0);
  assign rv[0] = '0;
  assign mv[0] = vld[LAT-1];

  for (genvar s = 0; s < MOD_STEPS; s++) begin : g_mod
    always_comb begin
      rs[s] = {rv[s][ARENA_W-1:0], qv[s][63]};
      if (rs[s] >= {1'b0, words}) rs[s] = rs[s] - {1'b0, words};
    end
    always_ff @(posedge clk) begin
      qv[s+1] <= {qv[s][62:0], 1'b0};
      rv[s+1] <= rs[s];
      if (rst) mv[s+1] <= 1'b0;
      else mv[s+1] <= mv[s];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= mv[MOD_STEPS];
    if (words == '0) byte_offset <= '0;
    else byte_offset <= OFFSET_W'(rv[MOD_STEPS][ARENA_W-1:0]) * OFFSET_W'(WORD_BYTES);
  end
endmodule
`default_nettype wire

// ===== sv/hrwo_checker.sv =====
// ----------------------------------------------------------------------------
// Hashed random word offset checker
// Port-level assertions on the offset unit, bound into the offset unit module.
// ----------------------------------------------------------------------------
`default_nettype none
module hrwo_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          done,
  input wire logic [hrwo_pkg::OFFSET_W-1:0] byte_offset
);
  import hrwo_pkg::*;

  a_lat: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##75 done) else $error("missing result");
  a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
  a_align: assert property (@(posedge clk) done |-> byte_offset[2:0] == 3'd0)
    else $error("offset not word aligned");
  a_rst: assert property (@(posedge clk) rst |=> !done)
    else $error("result after reset");
endmodule

bind hashed_random_word_offset_unit hrwo_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .byte_offset(byte_offset));
`default_nettype wire
